@@ design/utf8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int PART_W = 15;
    localparam int CNT_W  = 3;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

    // Lead byte classes: mask and pattern after masking.
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
    localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

    // Most results one byte can cause.
    localparam logic [CNT_W-1:0] MAX_RESULTS = 3'd4;

    // Results caused by one byte: cnt code points, all U+FFFD except the
    // final one, which is last_cp.
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CP_W-1:0]  last_cp;
    } t_job;

endpackage

@@ design/utf8d_if.sv @@
// Valid/ready stream interfaces for the byte input and the code point output.
interface utf8d_byte_if;
    logic                       valid;
    logic                       ready;
    logic [utf8d_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8d_cp_if;
    logic                     valid;
    logic                     ready;
    logic [utf8d_pkg::CP_W-1:0] code_point;
    logic                     last_of_run;

    modport source (output valid, output code_point, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

@@ design/utf8_stream_decoder.sv @@
// Top level: streaming UTF-8 decoder, one byte in, code points out.
// The first result of a byte passes through the queue count register and then the output register.
// Throughput: one byte per cycle while each byte gives at most one result and the output accepts; results
// leave at one per cycle while the output accepts; the next byte is taken as a byte's last result leaves.
// Reset: synchronous, active low; clears the open sequence and drops queued results.
module utf8_stream_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8d_byte_if.sink    i_byte,
    utf8d_cp_if.source    o_cp
);

    utf8d_pkg::t_job job;
    logic            accept;
    logic            in_ready;

    assign i_byte.ready = in_ready;
    assign accept       = i_byte.valid && in_ready;

    utf8d_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_byte.in_byte),
        .o_job    (job)
    );

    utf8d_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_job         (job),
        .o_in_ready    (in_ready),
        .o_valid       (o_cp.valid),
        .i_ready       (o_cp.ready),
        .o_code_point  (o_cp.code_point),
        .o_last_of_run (o_cp.last_of_run)
    );

endmodule

@@ design/utf8d_decode.sv @@
// Sequence state and per-byte decode into a group of pending results.
module utf8d_decode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [utf8d_pkg::BYTE_W-1:0] i_byte,
    output utf8d_pkg::t_job              o_job
);

    logic [utf8d_pkg::PART_W-1:0] r_partial, n_partial;
    logic [1:0]                   r_needed, n_needed;
    logic [1:0]                   r_taken, n_taken;

    always_comb begin
        logic [utf8d_pkg::CP_W-1:0]  v;
        logic [utf8d_pkg::CNT_W-1:0] flush;
        logic                        tail;
        logic                        is_cont;

        v       = {r_partial, i_byte[5:0]};
        is_cont = (i_byte & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_CODE;
        flush   = '0;
        tail    = 1'b0;

        n_partial     = r_partial;
        n_needed      = r_needed;
        n_taken       = r_taken;
        o_job.cnt     = '0;
        o_job.last_cp = utf8d_pkg::CP_REPLACEMENT;

        if (r_needed != 2'd0 && is_cont) begin
            if (r_needed == 2'd1) begin
                o_job.cnt     = 3'd1;
                o_job.last_cp = v;
                n_partial     = '0;
                n_needed      = 2'd0;
                n_taken       = 2'd0;
            end else begin
                n_partial = v[utf8d_pkg::PART_W-1:0];
                n_needed  = r_needed - 2'd1;
                n_taken   = r_taken + 2'd1;
            end
        end else begin
            // A broken sequence flushes one U+FFFD for the lead and one per
            // continuation taken, then the byte is decoded afresh; the terminator 0x00 gives no result.
            if (r_needed != 2'd0) begin
                flush = {1'b0, r_taken} + 3'd1;
            end
            n_partial = '0;
            n_needed  = 2'd0;
            n_taken   = 2'd0;
            if (i_byte != utf8d_pkg::TERMINATOR) begin
                priority if (i_byte[7] == 1'b0) begin
                    tail          = 1'b1;
                    o_job.last_cp = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, i_byte};
                end else if ((i_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_CODE) begin
                    n_partial = {{(utf8d_pkg::PART_W-5){1'b0}}, i_byte[4:0]};
                    n_needed  = 2'd1;
                end else if ((i_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_CODE) begin
                    n_partial = {{(utf8d_pkg::PART_W-4){1'b0}}, i_byte[3:0]};
                    n_needed  = 2'd2;
                end else if ((i_byte & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_CODE) begin
                    n_partial = {{(utf8d_pkg::PART_W-3){1'b0}}, i_byte[2:0]};
                    n_needed  = 2'd3;
                end else begin
                    tail = 1'b1;
                end
            end
            o_job.cnt = flush + {2'b00, tail};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_needed  <= 2'd0;
            r_taken   <= 2'd0;
        end else if (i_accept) begin
            r_partial <= n_partial;
            r_needed  <= n_needed;
            r_taken   <= n_taken;
        end
    end

    // The lead byte plus all continuations never exceed four bytes.
    a_seq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_needed} + {1'b0, r_taken}) <= 3'd3)
        else $error("open sequence longer than four bytes");

    // With no sequence open, nothing is left over from the last one.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_needed == 2'd0 |-> (r_taken == 2'd0 && r_partial == '0))
        else $error("idle decoder holds stale sequence state");

    // An accepted byte never causes more than four results.
    a_job_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> o_job.cnt <= utf8d_pkg::MAX_RESULTS)
        else $error("byte causes too many results");

endmodule

@@ design/utf8d_emit.sv @@
// Result queue for one byte's group of code points and the output register.
module utf8d_emit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  utf8d_pkg::t_job              i_job,
    output logic                         o_in_ready,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [utf8d_pkg::CP_W-1:0]   o_code_point,
    output logic                         o_last_of_run
);

    logic [utf8d_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [utf8d_pkg::CP_W-1:0]  r_last_cp;
    logic                        r_out_valid;
    logic [utf8d_pkg::CP_W-1:0]  r_out_cp;
    logic                        r_out_last;
    logic                        out_free;
    logic                        move;

    assign out_free   = !r_out_valid || i_ready;
    assign move       = (r_cnt != '0) && out_free;
    // A new group may load when the queue is empty or its final result
    // leaves in this cycle.
    assign o_in_ready = (r_cnt == '0) || (r_cnt == 3'd1 && out_free);

    always_comb begin
        n_cnt = r_cnt;
        if (move) begin
            n_cnt = r_cnt - 3'd1;
        end
        if (i_accept && i_job.cnt != '0) begin
            n_cnt = i_job.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_job.cnt != '0) begin
            r_last_cp <= i_job.last_cp;
        end
        if (move) begin
            r_out_cp   <= (r_cnt == 3'd1) ? r_last_cp : utf8d_pkg::CP_REPLACEMENT;
            r_out_last <= (r_cnt == 3'd1);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_code_point  = r_out_cp;
    assign o_last_of_run = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= utf8d_pkg::MAX_RESULTS)
        else $error("result queue count out of range");

    // While a run is incomplete, the rest of it is still queued.
    a_run_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> r_cnt != '0)
        else $error("run shown unfinished with nothing queued");

    // Moving the final queued result marks the end of the run.
    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_cnt == 3'd1) |=> (r_out_valid && r_out_last))
        else $error("final result of a run not marked");

endmodule
